### design/chat_packet_field_parser_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chat packet field parser
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CHAT_PACKET_FIELD_PARSER_CORE_ASSERT_SVH
`define CHAT_PACKET_FIELD_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CPFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpfp check failed");
`define CPFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpfp check failed");
`else
`define CPFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define CPFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/cpfp_pkg.sv
// ---------------------------------------------------------------------------
// cpfp_pkg
// Shared types and codes of the chat packet field parser.
// ---------------------------------------------------------------------------
package cpfp_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   // register index is the byte address over four
   localparam logic CSR_IDX_PACKET_ID = 1'b0;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] KIND_PLAYER  = 2'd0;
   localparam logic [1:0] KIND_NAME    = 2'd1;
   localparam logic [1:0] KIND_MESSAGE = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_WRONG_ID  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // results of one byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic                 room_for_two;
      logic [RSP_CNT_W-1:0] count;
   } queue_status_type;

endpackage

### design/cpfp_if.sv
// ---------------------------------------------------------------------------
// cpfp channel interfaces
// Valid/ready channels for packet bytes and for parse results.
// ---------------------------------------------------------------------------
interface cpfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface cpfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] value;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, output kind, output value, output status, output last,
                   input ready);
   modport sink   (input valid, input kind, input value, input status, input last,
                   output ready);
endinterface

### design/chat_packet_field_parser_core.sv
// ---------------------------------------------------------------------------
// chat_packet_field_parser_core
// Byte-wise parser of chat packets: identifier check, player id, name, message.
// ---------------------------------------------------------------------------
// Path: a byte accepted into the hold register yields its results at the rsp
//   port through the hold register, parse step, then the result queue head.
// Throughput: one byte per cycle while the result queue has room for two; a
//   final byte with a data item makes two result beats, so output pops bound the sustained rate.
// Reset (synchronous, high): parse state back to identifier high byte,
//   queue emptied, packet_id register cleared to zero.
module chat_packet_field_parser_core
   import cpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cpfp_req_if.sink              req_bus,
   cpfp_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "chat_packet_field_parser_core_assert.svh"

   logic [15:0]      packet_id;
   push_type         push;
   queue_status_type q_status;
   result_type       head;
   logic             head_valid;
   logic             req_ready;

   // register block; the user must write config only while the parser is idle; the block does not enforce it
   cpfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .packet_id (packet_id)
   );

   // hold register plus parse step; steps only when the queue has two free slots
   cpfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_ready),
      .in_byte      (req_bus.data_byte),
      .in_eop       (req_bus.end_of_packet),
      .packet_id    (packet_id),
      .room_for_two (q_status.room_for_two),
      .push         (push)
   );

   assign req_bus.ready = req_ready;

   // result queue decouples the two sides; a beat waits here for rsp ready
   cpfp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_bus.ready),
      .out_valid (head_valid),
      .out_item  (head),
      .status    (q_status)
   );

   assign rsp_bus.valid  = head_valid;
   assign rsp_bus.kind   = head.kind;
   assign rsp_bus.value  = head.value;
   assign rsp_bus.status = head.status;
   assign rsp_bus.last   = head.last;

   // queue fill never runs past its depth
   `CPFP_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_status.count <= RSP_CNT_W'(RSP_DEPTH))
   // anything pushed shows up at the rsp port next cycle
   `CPFP_ASSERT_NEXT(a_push_visible, clock, reset, push.count != 2'd0, rsp_bus.valid)
   // the closing beat is always a verdict
   `CPFP_ASSERT_SAME(a_last_verdict, clock, reset, rsp_bus.valid && rsp_bus.last,
                     rsp_bus.kind == KIND_VERDICT)
   // a pair of results is always data item then verdict
   `CPFP_ASSERT_SAME(a_pair_order, clock, reset, push.count == 2'd2,
                     !push.first.last && push.second.last)

endmodule

### design/cpfp_csr.sv
// ---------------------------------------------------------------------------
// cpfp_csr
// APB-style register holding the chat packet identifier.
// ---------------------------------------------------------------------------
module cpfp_csr
   import cpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [15:0]           packet_id
);

   logic [15:0] packet_id_ff;
   logic [15:0] packet_id_in;
   logic        sel_id;

   assign sel_id = (paddr[CSR_ADDR_W-1] == CSR_IDX_PACKET_ID);
   assign pready = 1'b1;

   always_comb begin
      packet_id_in = packet_id_ff;
      if (psel && penable && pwrite && sel_id) begin
         packet_id_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_id_ff <= '0;
      end else begin
         packet_id_ff <= packet_id_in;
      end
   end

   assign prdata    = sel_id ? {{(CSR_DATA_W-16){1'b0}}, packet_id_ff} : '0;
   assign packet_id = packet_id_ff;

endmodule

### design/cpfp_parser.sv
// ---------------------------------------------------------------------------
// cpfp_parser
// Input register and field parse step; emits up to two results per byte.
// ---------------------------------------------------------------------------
module cpfp_parser
   import cpfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_eop,
   input  logic [15:0] packet_id,
   input  logic        room_for_two,
   output push_type    push
);

   typedef enum logic [2:0] {
      PH_ID_HI, PH_ID_LO, PH_PLAYER, PH_NAME_LEN,
      PH_NAME, PH_MLEN_HI, PH_MLEN_LO, PH_MESSAGE
   } phase_type;

   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        hold_eop_ff, hold_eop_in;

   phase_type   phase_ff, phase_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [31:0] assembly_ff, assembly_in;
   logic        failed_ff, failed_in;

   logic        fire;
   logic        accept;
   logic        item_valid;
   result_type  item;
   result_type  verdict;

   assign fire     = hold_valid_ff && room_for_two;
   assign in_ready = !hold_valid_ff || room_for_two;
   assign accept   = in_valid && in_ready;

   always_comb begin
      hold_valid_in = fire ? 1'b0 : hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_eop_in   = hold_eop_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = in_byte;
         hold_eop_in   = in_eop;
      end
   end

   always_comb begin
      logic [7:0] b;
      b            = hold_byte_ff;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      assembly_in  = assembly_ff;
      failed_in    = failed_ff;
      item_valid   = 1'b0;
      item         = '{kind: KIND_PLAYER, value: 32'd0, status: STATUS_OK, last: 1'b0};
      if (!failed_ff) begin
         case (phase_ff)
            PH_ID_HI: begin
               assembly_in = {24'd0, b};
               phase_in    = PH_ID_LO;
            end
            PH_ID_LO: begin
               if ({assembly_ff[7:0], b} != packet_id) begin
                  failed_in = 1'b1;
               end else begin
                  assembly_in  = '0;
                  remaining_in = 16'd4;
                  phase_in     = PH_PLAYER;
               end
            end
            PH_PLAYER: begin
               assembly_in  = {assembly_ff[23:0], b};
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  item_valid = 1'b1;
                  item.kind  = KIND_PLAYER;
                  item.value = {assembly_ff[23:0], b};
                  phase_in   = PH_NAME_LEN;
               end
            end
            PH_NAME_LEN: begin
               remaining_in = {8'd0, b};
               phase_in     = (b == 8'd0) ? PH_MLEN_HI : PH_NAME;
            end
            PH_NAME: begin
               item_valid   = 1'b1;
               item.kind    = KIND_NAME;
               item.value   = {24'd0, b};
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  phase_in = PH_MLEN_HI;
               end
            end
            PH_MLEN_HI: begin
               assembly_in = {24'd0, b};
               phase_in    = PH_MLEN_LO;
            end
            PH_MLEN_LO: begin
               remaining_in = {assembly_ff[7:0], b};
               phase_in     = PH_MESSAGE;
            end
            PH_MESSAGE: begin
               if (remaining_ff != 16'd0) begin
                  item_valid   = 1'b1;
                  item.kind    = KIND_MESSAGE;
                  item.value   = {24'd0, b};
                  remaining_in = remaining_ff - 16'd1;
               end
            end
            default: begin
               phase_in = PH_ID_HI;
            end
         endcase
      end

      // verdict looks at the state after this byte
      verdict = '{kind: KIND_VERDICT, value: 32'd0, status: STATUS_TRUNCATED, last: 1'b1};
      if (failed_in) begin
         verdict.status = STATUS_WRONG_ID;
      end else if (phase_in == PH_MESSAGE && remaining_in == 16'd0) begin
         verdict.status = STATUS_OK;
      end

      push.count  = 2'd0;
      push.first  = item;
      push.second = verdict;
      if (fire) begin
         if (item_valid) begin
            push.count = hold_eop_ff ? 2'd2 : 2'd1;
         end else if (hold_eop_ff) begin
            push.count = 2'd1;
            push.first = verdict;
         end
      end

      if (!fire) begin
         phase_in     = phase_ff;
         remaining_in = remaining_ff;
         assembly_in  = assembly_ff;
         failed_in    = failed_ff;
      end else if (hold_eop_ff) begin
         phase_in     = PH_ID_HI;
         remaining_in = '0;
         assembly_in  = '0;
         failed_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_ID_HI;
         remaining_ff  <= '0;
         assembly_ff   <= '0;
         failed_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         assembly_ff   <= assembly_in;
         failed_ff     <= failed_in;
      end
      hold_byte_ff <= hold_byte_in;
      hold_eop_ff  <= hold_eop_in;
   end

endmodule

### design/cpfp_rsp_queue.sv
// ---------------------------------------------------------------------------
// cpfp_rsp_queue
// Small result queue: up to two pushes and one pop per cycle.
// ---------------------------------------------------------------------------
module cpfp_rsp_queue
   import cpfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output logic             out_valid,
   output result_type       out_item,
   output queue_status_type status
);

   result_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_pop;
   logic [RSP_PTR_W-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;
   assign wr_next   = wr_ptr_ff + RSP_PTR_W'(1);

   assign status.room_for_two = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign status.count        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.second;
      end
   end

endmodule

### test/chat_packet_field_parser_core_test.sv
// ---------------------------------------------------------------------------
// chat_packet_field_parser_core_test
// Self-checking bench for the chat packet parser: byte beats go in over the
// request channel, every result beat is compared with a local parse model,
// and the packet identifier register is changed between traffic phases.
// ---------------------------------------------------------------------------
module chat_packet_field_parser_core_test;
   import cpfp_pkg::*;

   // --- bench limits -------------------------------------------------------
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat of any kind
   localparam int SETTLE_CYCLES  = 4;     // hold reg + parse step + queue head
   localparam int BEATS_PER_RUN  = 200;   // parsed bytes per register setting
   localparam logic [CSR_ADDR_W-1:0] PACKET_ID_ADDR = {CSR_IDX_PACKET_ID, 2'b00};

   // parse phases of the local model
   typedef enum logic [2:0] {
      WAIT_ID_HI, WAIT_ID_LO, WAIT_PLAYER, WAIT_NAME_LEN,
      WAIT_NAME, WAIT_MLEN_HI, WAIT_MLEN_LO, WAIT_MESSAGE
   } parse_phase_type;

   // one request beat; 'typed' rows carry their single result written out
   typedef struct packed {
      logic [7:0] data;
      logic       eop;
      logic       typed;
      result_type want;
   } beat_type;

   localparam result_type NO_RESULT      = '0;
   localparam result_type VERDICT_OK     = '{KIND_VERDICT, 32'd0, STATUS_OK, 1'b1};
   localparam result_type VERDICT_WRONG  = '{KIND_VERDICT, 32'd0, STATUS_WRONG_ID, 1'b1};
   localparam result_type VERDICT_TRUNC  = '{KIND_VERDICT, 32'd0, STATUS_TRUNCATED, 1'b1};
   localparam result_type PLAYER_ONES    = '{KIND_PLAYER, 32'hFFFF_FFFF, STATUS_OK, 1'b0};
   localparam result_type PLAYER_ZERO    = '{KIND_PLAYER, 32'd0, STATUS_OK, 1'b0};

   // Directed packets, register still at its reset value of zero:
   //  - identifier matches but packet ends right after it -> truncated
   //  - identifier mismatch, trailing byte ignored        -> wrong identifier
   //  - all-ones player, empty name, 2-byte message, one byte past the
   //    message carrying the end flag                      -> ok
   //  - all-zero player, name of FF 00, empty message, end on length low
   //    byte                                               -> ok
   localparam beat_type DIRECTED_BEATS [28] = '{
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1, VERDICT_TRUNC},
      '{8'h12, 1'b0, 1'b0, NO_RESULT},
      '{8'h34, 1'b0, 1'b0, NO_RESULT},
      '{8'h56, 1'b1, 1'b1, VERDICT_WRONG},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b1, PLAYER_ONES},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b1, 1'b1, VERDICT_OK},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, PLAYER_ZERO},
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1, VERDICT_OK}
   };

   // --- clock, reset, channels ---------------------------------------------
   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   cpfp_req_if req_ch ();
   cpfp_rsp_if rsp_ch ();

   chat_packet_field_parser_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // --- parse model state --------------------------------------------------
   logic [15:0]     packet_id_cfg;   // mirror of the identifier register
   parse_phase_type parse_phase;
   logic [15:0]     bytes_left;
   logic [31:0]     field_acc;
   logic            id_rejected;

   result_type   step_results [$];      // results of the byte just parsed
   result_type   pending_results [$];   // oldest first, awaiting rsp beats
   beat_type     outgoing_beats [$];    // bytes of the packet being sent
   beat_type     driven_beat;           // what sits on the request bus now

   int parsed_beats;
   int fail_count;
   int idle_cycles;
   int burst_left;
   int hold_off_cycles;

   function automatic void clear_parse_state();
      parse_phase = WAIT_ID_HI;
      bytes_left  = '0;
      field_acc   = '0;
      id_rejected = 1'b0;
   endfunction

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [31:0] value,
                                              input logic [1:0] status,
                                              input logic last);
      result_type r;
      r.kind   = kind;
      r.value  = value;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // Advance the parse by one byte; results land in step_results.
   function automatic void parse_chat_byte(input logic [7:0] b, input logic eop);
      logic [1:0] verdict;
      step_results.delete();
      // bytes after a rejected id or after a finished message do nothing
      if (!id_rejected && !(parse_phase == WAIT_MESSAGE && bytes_left == 0))
         parsed_beats++;
      else if (eop)
         parsed_beats++;
      if (!id_rejected) begin
         case (parse_phase)
            WAIT_ID_HI: begin
               field_acc   = {24'd0, b};
               parse_phase = WAIT_ID_LO;
            end
            WAIT_ID_LO: begin
               if ({field_acc[7:0], b} != packet_id_cfg) begin
                  id_rejected = 1'b1;
               end else begin
                  field_acc   = '0;
                  bytes_left  = 16'd4;
                  parse_phase = WAIT_PLAYER;
               end
            end
            WAIT_PLAYER: begin
               field_acc  = {field_acc[23:0], b};
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 0) begin
                  step_results.push_back(make_result(KIND_PLAYER, field_acc, STATUS_OK, 1'b0));
                  parse_phase = WAIT_NAME_LEN;
               end
            end
            WAIT_NAME_LEN: begin
               bytes_left  = {8'd0, b};
               parse_phase = (b == 8'd0) ? WAIT_MLEN_HI : WAIT_NAME;
            end
            WAIT_NAME: begin
               step_results.push_back(make_result(KIND_NAME, {24'd0, b}, STATUS_OK, 1'b0));
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 0)
                  parse_phase = WAIT_MLEN_HI;
            end
            WAIT_MLEN_HI: begin
               field_acc   = {24'd0, b};
               parse_phase = WAIT_MLEN_LO;
            end
            WAIT_MLEN_LO: begin
               bytes_left  = {field_acc[7:0], b};
               parse_phase = WAIT_MESSAGE;
            end
            default: begin
               if (bytes_left != 0) begin
                  step_results.push_back(make_result(KIND_MESSAGE, {24'd0, b}, STATUS_OK,
                                                     1'b0));
                  bytes_left = bytes_left - 16'd1;
               end
            end
         endcase
      end
      if (eop) begin
         if (id_rejected)
            verdict = STATUS_WRONG_ID;
         else if (parse_phase == WAIT_MESSAGE && bytes_left == 0)
            verdict = STATUS_OK;
         else
            verdict = STATUS_TRUNCATED;
         step_results.push_back(make_result(KIND_VERDICT, 32'd0, verdict, 1'b1));
         clear_parse_state();
      end
   endfunction

   function automatic void match_result(input result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result beat kind=%0d value=%h status=%0d last=%0b",
                  $time, got.kind, got.value, got.status, got.last);
      end else begin
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.status !== want.status || got.last !== want.last) begin
            fail_count++;
            $display({"%0t: result mismatch, expected kind=%0d value=%h status=%0d ",
                      "last=%0b, actual kind=%0d value=%h status=%0d last=%0b"},
                     $time, want.kind, want.value, want.status, want.last,
                     got.kind, got.value, got.status, got.last);
         end
      end
   endfunction

   // --- monitor and watchdog: everything sampled at the rising edge --------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles = 0;
            match_result(make_result(rsp_ch.kind, rsp_ch.value, rsp_ch.status, rsp_ch.last));
         end
         if (req_ch.valid && req_ch.ready) begin
            idle_cycles = 0;
            parse_chat_byte(req_ch.data_byte, req_ch.end_of_packet);
            if (driven_beat.typed)
               pending_results.push_back(driven_beat.want);
            else
               foreach (step_results[i]) pending_results.push_back(step_results[i]);
         end
         if (psel && penable && pready)
            idle_cycles = 0;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // --- result side: own stall pattern, plus a long hold-off on request ----
   initial begin
      int   style;
      int   pattern_left;
      logic [31:0] stall_bits;
      rsp_ch.ready = 1'b0;
      pattern_left = 0;
      style = 0;
      stall_bits = '1;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            if (pattern_left == 0) begin
               style        = $urandom_range(0, 3);
               stall_bits   = $urandom;
               pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (style)
               0: begin
                  rsp_ch.ready <= 1'b1;            // no stalls at all
               end
               1: begin
                  rsp_ch.ready <= stall_bits[0];   // repeating pattern of stall_bits
                  stall_bits = {stall_bits[0], stall_bits[31:1]};
               end
               2: begin
                  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // --- request side ------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input beat_type b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      driven_beat = b;
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= b.data;
      req_ch.end_of_packet <= b.eop;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stop offering beats until every expected result has been taken.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      // a byte with no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_packet_id(input logic [15:0] id);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PACKET_ID_ADDR;
      pwdata  <= {16'd0, id};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      packet_id_cfg = id;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Build one packet into outgoing_beats. Mostly well-formed with random
   // content; some carry a wrong id, are cut short, carry junk after the
   // message, or are plain noise.
   task automatic queue_chat_packet();
      logic [7:0]  raw [$];
      logic [15:0] id;
      logic [31:0] player;
      int pick, name_len, msg_len, msg_bytes, keep;
      beat_type b;
      raw.delete();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom_range(0, 255)));
      end else begin
         id = packet_id_cfg;
         if (pick < 15)
            id = id ^ (16'h1 << $urandom_range(0, 15));   // one bit off
         player = $urandom;
         pick = $urandom_range(0, 99);
         name_len = (pick < 60) ? $urandom_range(0, 6)
                  : (pick < 90) ? $urandom_range(7, 24) : $urandom_range(25, 255);
         pick = $urandom_range(0, 99);
         msg_len = (pick < 40) ? $urandom_range(0, 8)
                 : (pick < 70) ? $urandom_range(9, 40)
                 : (pick < 75) ? $urandom_range(41, 300) : $urandom_range(0, 65535);
         // long random lengths are sent short, so those packets end truncated
         msg_bytes = (msg_len <= 300) ? msg_len : $urandom_range(0, 12);
         raw.push_back(id[15:8]);
         raw.push_back(id[7:0]);
         for (int i = 3; i >= 0; i--) raw.push_back(player[8*i +: 8]);
         raw.push_back(name_len[7:0]);
         repeat (name_len) raw.push_back(8'($urandom_range(0, 255)));
         raw.push_back(msg_len[15:8]);
         raw.push_back(msg_len[7:0]);
         repeat (msg_bytes) raw.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) raw.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 99) < 15) begin
            keep = $urandom_range(1, raw.size());
            while (raw.size() > keep) void'(raw.pop_back());
         end
      end
      foreach (raw[i]) begin
         b.data  = raw[i];
         b.eop   = (i == raw.size() - 1);
         b.typed = 1'b0;
         b.want  = NO_RESULT;
         outgoing_beats.push_back(b);
      end
   endtask

   // --- main sequence -------------------------------------------------------
   initial begin
      logic [15:0] id_settings [5];
      int target;
      int packets;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = '0;
      req_ch.end_of_packet = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      packet_id_cfg        = '0;
      driven_beat          = '0;
      parsed_beats         = 0;
      fail_count           = 0;
      burst_left           = 0;
      hold_off_cycles      = 0;
      clear_parse_state();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed packets against the reset value of the register
      foreach (DIRECTED_BEATS[i]) send_beat(DIRECTED_BEATS[i]);

      // random traffic under several identifier settings, extremes included
      id_settings = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
      id_settings[1] = 16'($urandom);
      id_settings[3] = 16'($urandom);
      id_settings[4] = 16'($urandom);
      foreach (id_settings[run]) begin
         drain_results();
         write_packet_id(id_settings[run]);
         target  = parsed_beats + BEATS_PER_RUN;
         packets = 0;
         while (parsed_beats < target) begin
            // result side goes deaf for a while; the queue fills and the
            // request side must back off
            if (run == 1 && packets == 10)
               hold_off_cycles = 300;
            // sender waits for the pipe to empty mid-run
            if (run == 2 && packets == 10)
               drain_results();
            queue_chat_packet();
            while (outgoing_beats.size() != 0) send_beat(outgoing_beats.pop_front());
            packets++;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         fail_count += pending_results.size();
         $display("%0t: %0d expected result beats never arrived", $time,
                  pending_results.size());
      end
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/cpfp_pkg.sv
design/cpfp_if.sv
design/cpfp_csr.sv
design/cpfp_parser.sv
design/cpfp_rsp_queue.sv
design/chat_packet_field_parser_core.sv
test/chat_packet_field_parser_core_test.sv
